// ===== src/pps_pkg.sv =====
// pps_pkg: shared types and constants of the preemptive priority scheduler
// no dependencies; imported by pps_pick, the top level, the checker and the testbench
package pps_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int ID_W   = 8;
  localparam int TIME_W = 16;
  localparam int PRIO_W = 8;
  localparam int CLK_W  = 32;
  localparam int SUM_W  = 40;

  // one process slot as it sits in the entry ram
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/pps_ram.sv =====
// pps_ram: generic single write, single read ram with registered read data
// no dependencies
module pps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pps_pick.sv =====
// pps_pick: shared compare unit that keeps the best ready slot during a scan
// depends on pps_pkg
module pps_pick
  import pps_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             cand_valid_i,
  input  logic [IDX_W-1:0] cand_idx_i,
  input  logic             cand_done_i,
  input  entry_t           cand_entry_i,
  input  logic [CLK_W-1:0] clock_time_i,
  output logic             best_found_o,
  output logic [IDX_W-1:0] best_idx_o,
  output entry_t           best_entry_o
);

  logic             found_q, found_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  entry_t           entry_q, entry_d;
  logic             ready;
  logic             better;

  // candidate is ready when unfinished and already arrived
  assign ready = cand_valid_i && !cand_done_i &&
                 ({{(CLK_W-TIME_W){1'b0}}, cand_entry_i.arrival} <= clock_time_i);

  // smaller priority wins, then earlier arrival, then the lower slot seen first
  assign better = !found_q ||
                  (cand_entry_i.prio < entry_q.prio) ||
                  ((cand_entry_i.prio == entry_q.prio) &&
                   (cand_entry_i.arrival < entry_q.arrival));

  always_comb begin
    found_d = found_q;
    idx_d   = idx_q;
    entry_d = entry_q;
    if (clear_i) begin
      found_d = 1'b0;
    end else if (ready && better) begin
      found_d = 1'b1;
      idx_d   = cand_idx_i;
      entry_d = cand_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  // best slot payload
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    entry_q <= entry_d;
  end

  assign best_found_o = found_q;
  assign best_idx_o   = idx_q;
  assign best_entry_o = entry_q;

endmodule

// ===== src/preemptive_priority_scheduler_unit.sv =====
// preemptive priority scheduler: after a load word the input stays ready
// a tick word scans one slot per cycle through the entry ram read port and
// the shared compare unit, then passes through ST_TA, ST_WT and ST_SUM_WT
// when the process completes, and then waits in ST_EMIT for the output
// register to free up; one word at a time; stall stays high for the whole tick
// reset clears counters, time, sums and done flags at once; no clearing pass
module preemptive_priority_scheduler_unit
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [ID_W-1:0]   process_id_i,
  input  logic [TIME_W-1:0] arrival_i,
  input  logic [TIME_W-1:0] burst_i,
  input  logic [PRIO_W-1:0] priority_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              ran_valid_o,
  output logic [ID_W-1:0]   ran_id_o,
  output logic [CLK_W-1:0]  now_o,
  output logic              finished_o,
  output logic [CLK_W-1:0]  finish_time_o,
  output logic [CLK_W-1:0]  turnaround_o,
  output logic [CLK_W-1:0]  waiting_o,
  output logic [SUM_W-1:0]  total_turnaround_o,
  output logic [SUM_W-1:0]  total_waiting_o,
  output logic              all_done_o
);

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_TA     = 3'd2;
  localparam logic [2:0] ST_WT     = 3'd3;
  localparam logic [2:0] ST_SUM_WT = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCS);
  localparam logic [CLK_W-1:0] CLK_MAX  = {CLK_W{1'b1}};

  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     loaded_q, loaded_d;
  logic [CNT_W-1:0]     done_cnt_q, done_cnt_d;
  logic [CNT_W-1:0]     scan_q, scan_d;
  logic                 rd_valid_q, rd_valid_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic [MAX_PROCS-1:0] done_q, done_d;
  logic [CLK_W-1:0]     clock_q, clock_d;
  logic [SUM_W-1:0]     sum_ta_q, sum_ta_d;
  logic [SUM_W-1:0]     sum_wt_q, sum_wt_d;

  logic                 ran_q, ran_d;
  logic [ID_W-1:0]      ran_id_q, ran_id_d;
  logic                 fin_q, fin_d;
  logic [CLK_W-1:0]     ta_q, ta_d;
  logic [CLK_W-1:0]     wt_q, wt_d;

  logic                 out_valid_q, out_valid_d;
  logic                 o_ran_q, o_fin_q, o_all_done_q;
  logic [ID_W-1:0]      o_id_q;
  logic [CLK_W-1:0]     o_now_q, o_fin_time_q, o_ta_q, o_wt_q;
  logic [SUM_W-1:0]     o_sum_ta_q, o_sum_wt_q;

  logic                 in_fire;
  logic                 emit_fire;
  logic                 clear;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  entry_t               wentry;
  logic [IDX_W-1:0]     raddr;
  logic [ENTRY_W-1:0]   rdata;
  entry_t               rentry;

  logic                 best_found;
  logic [IDX_W-1:0]     best_idx;
  entry_t               best_entry;

  logic [SUM_W:0]       sum_ext;
  logic [CLK_W-1:0]     burst_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign emit_fire  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign clear      = in_fire && operation_i;
  assign rentry     = entry_t'(rdata);
  assign burst_ext  = {{(CLK_W-TIME_W){1'b0}}, best_entry.burst};

  // entry table
  pps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (ENTRY_W'(wentry)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared compare unit
  pps_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (clear),
    .cand_valid_i (rd_valid_q),
    .cand_idx_i   (rd_idx_q),
    .cand_done_i  (done_q[rd_idx_q]),
    .cand_entry_i (rentry),
    .clock_time_i (clock_q),
    .best_found_o (best_found),
    .best_idx_o   (best_idx),
    .best_entry_o (best_entry)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    loaded_d   = loaded_q;
    done_cnt_d = done_cnt_q;
    scan_d     = scan_q;
    rd_valid_d = 1'b0;
    rd_idx_d   = rd_idx_q;
    done_d     = done_q;
    clock_d    = clock_q;
    sum_ta_d   = sum_ta_q;
    sum_wt_d   = sum_wt_q;
    ran_d      = ran_q;
    ran_id_d   = ran_id_q;
    fin_d      = fin_q;
    ta_d       = ta_q;
    wt_d       = wt_q;
    we         = 1'b0;
    waddr      = best_idx;
    wentry     = best_entry;
    raddr      = scan_q[IDX_W-1:0];
    sum_ext    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!operation_i) begin
            // load into the next free slot, dropped when full
            if (loaded_q != CNT_FULL) begin
              we               = 1'b1;
              waddr            = loaded_q[IDX_W-1:0];
              wentry.id        = process_id_i;
              wentry.arrival   = arrival_i;
              wentry.burst     = burst_i;
              wentry.remaining = burst_i;
              wentry.prio      = priority_req_i;
              done_d[loaded_q[IDX_W-1:0]] = 1'b0;
              loaded_d         = loaded_q + 1'b1;
            end
          end else begin
            scan_d  = '0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, compare sees the read data in the cycle after
        if (scan_q < loaded_q) begin
          rd_valid_d = 1'b1;
          rd_idx_d   = scan_q[IDX_W-1:0];
          scan_d     = scan_q + 1'b1;
        end else if (!rd_valid_q) begin
          if (clock_q != CLK_MAX) begin
            clock_d = clock_q + 1'b1;
          end
          ran_d    = best_found;
          ran_id_d = best_found ? best_entry.id : '0;
          fin_d    = 1'b0;
          ta_d     = '0;
          wt_d     = '0;
          state_d  = ST_EMIT;
          if (best_found) begin
            we = 1'b1;
            if (best_entry.remaining <= TIME_W'(1)) begin
              wentry.remaining = '0;
              done_d[best_idx] = 1'b1;
              done_cnt_d       = done_cnt_q + 1'b1;
              fin_d            = 1'b1;
              state_d          = ST_TA;
            end else begin
              wentry.remaining = best_entry.remaining - 1'b1;
            end
          end
        end
      end

      ST_TA: begin
        ta_d    = clock_q - {{(CLK_W-TIME_W){1'b0}}, best_entry.arrival};
        state_d = ST_WT;
      end

      ST_WT: begin
        // waiting floored at zero, turnaround sum saturates
        wt_d    = (ta_q >= burst_ext) ? (ta_q - burst_ext) : '0;
        sum_ext = {1'b0, sum_ta_q} + {{(SUM_W-CLK_W+1){1'b0}}, ta_q};
        sum_ta_d = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        state_d = ST_SUM_WT;
      end

      ST_SUM_WT: begin
        sum_ext = {1'b0, sum_wt_q} + {{(SUM_W-CLK_W+1){1'b0}}, wt_q};
        sum_wt_d = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (emit_fire) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output word handshake
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      loaded_q    <= '0;
      done_cnt_q  <= '0;
      scan_q      <= '0;
      rd_valid_q  <= 1'b0;
      done_q      <= '0;
      clock_q     <= '0;
      sum_ta_q    <= '0;
      sum_wt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      done_cnt_q  <= done_cnt_d;
      scan_q      <= scan_d;
      rd_valid_q  <= rd_valid_d;
      done_q      <= done_d;
      clock_q     <= clock_d;
      sum_ta_q    <= sum_ta_d;
      sum_wt_q    <= sum_wt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    ran_q    <= ran_d;
    ran_id_q <= ran_id_d;
    fin_q    <= fin_d;
    ta_q     <= ta_d;
    wt_q     <= wt_d;
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      o_ran_q      <= ran_q;
      o_id_q       <= ran_id_q;
      o_now_q      <= clock_q;
      o_fin_q      <= fin_q;
      o_fin_time_q <= fin_q ? clock_q : '0;
      o_ta_q       <= ta_q;
      o_wt_q       <= wt_q;
      o_sum_ta_q   <= sum_ta_q;
      o_sum_wt_q   <= sum_wt_q;
      o_all_done_q <= (done_cnt_q == loaded_q);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign ran_valid_o        = o_ran_q;
  assign ran_id_o           = o_id_q;
  assign now_o              = o_now_q;
  assign finished_o         = o_fin_q;
  assign finish_time_o      = o_fin_time_q;
  assign turnaround_o       = o_ta_q;
  assign waiting_o          = o_wt_q;
  assign total_turnaround_o = o_sum_ta_q;
  assign total_waiting_o    = o_sum_wt_q;
  assign all_done_o         = o_all_done_q;

endmodule

// ===== src/pps_checker.sv =====
// pps_checker: port level assertions for the priority scheduler top level
// depends on pps_pkg; bound to preemptive_priority_scheduler_unit below
module pps_checker
  import pps_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              operation_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              ran_valid_o,
  input logic [CLK_W-1:0]  now_o,
  input logic              finished_o,
  input logic [CLK_W-1:0]  finish_time_o,
  input logic [CLK_W-1:0]  turnaround_o,
  input logic [CLK_W-1:0]  waiting_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(now_o))
    else $error("stalled output word changed");

  // a load word leaves the input ready in the cycle after it is taken
  a_load_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !operation_i |=> !in_stall_o)
    else $error("load did not return to ready");

  // a tick word keeps the input stalled while it scans
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i |=> in_stall_o)
    else $error("tick did not hold off input");

  // an idle tick reports no completion data
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ran_valid_o |-> !finished_o && (finish_time_o == '0) &&
    (turnaround_o == '0) && (waiting_o == '0))
    else $error("idle tick carries completion data");

  // completion times are consistent
  a_fin_times: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> ran_valid_o && (finish_time_o == now_o) &&
    (waiting_o <= turnaround_o) && (turnaround_o <= finish_time_o))
    else $error("inconsistent completion times");

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (.*);

// ===== verif/tb_preemptive_priority_scheduler_unit.sv =====
// testbench for preemptive_priority_scheduler_unit: directed table, then random loads and ticks
// each tick report is checked against an in-bench scheduler predictor or a fixed directed row; depends on pps_pkg
`timescale 1ns / 100ps

module tb_preemptive_priority_scheduler_unit;
  import pps_pkg::*;

  localparam int SLOTS       = MAX_PROCS_DEF;
  localparam int RAND_ITEMS  = 1250;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 60;
  localparam logic [SUM_W-1:0] SUM_SAT = '1;
  localparam logic [CLK_W-1:0] TIME_SAT = '1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } sched_op_e;

  typedef struct packed {
    sched_op_e         op;
    logic [ID_W-1:0]   pid;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
  } sched_word_t;

  typedef struct packed {
    logic              ran_valid;
    logic [ID_W-1:0]   ran_id;
    logic [CLK_W-1:0]  now;
    logic              finished;
    logic [CLK_W-1:0]  finish_time;
    logic [CLK_W-1:0]  turnaround;
    logic [CLK_W-1:0]  waiting;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
    logic              all_done;
  } tick_report_t;

  typedef struct packed {
    sched_word_t  word;
    logic         has_fixed;
    tick_report_t fixed;
  } directed_row_t;

  // clock, reset and bench-driven signals
  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              in_valid       = 1'b0;
  logic              operation      = 1'b0;
  logic [ID_W-1:0]   process_id     = '0;
  logic [TIME_W-1:0] arrival        = '0;
  logic [TIME_W-1:0] burst          = '0;
  logic [PRIO_W-1:0] priority_req   = '0;
  logic              out_stall      = 1'b0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic              ran_valid_o;
  logic [ID_W-1:0]   ran_id_o;
  logic [CLK_W-1:0]  now_o;
  logic              finished_o;
  logic [CLK_W-1:0]  finish_time_o;
  logic [CLK_W-1:0]  turnaround_o;
  logic [CLK_W-1:0]  waiting_o;
  logic [SUM_W-1:0]  total_turnaround_o;
  logic [SUM_W-1:0]  total_waiting_o;
  logic              all_done_o;

  int fail_count = 0;
  int cycle_cnt  = 0;

  // predictor copy of the process table and counters
  logic [ID_W-1:0]   slot_id      [SLOTS];
  logic [TIME_W-1:0] slot_arrival [SLOTS];
  logic [TIME_W-1:0] slot_burst   [SLOTS];
  logic [TIME_W-1:0] slot_left    [SLOTS];
  logic [PRIO_W-1:0] slot_prio    [SLOTS];
  logic              slot_done    [SLOTS];
  int                n_loaded = 0;
  int                n_done   = 0;
  logic [CLK_W-1:0]  cur_time = '0;
  logic [SUM_W-1:0]  sum_ta   = '0;
  logic [SUM_W-1:0]  sum_wt   = '0;

  tick_report_t  expected_reports [$];
  directed_row_t directed_tbl     [$];

  preemptive_priority_scheduler_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation),
    .process_id_i       (process_id),
    .arrival_i          (arrival),
    .burst_i            (burst),
    .priority_req_i     (priority_req),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .ran_valid_o        (ran_valid_o),
    .ran_id_o           (ran_id_o),
    .now_o              (now_o),
    .finished_o         (finished_o),
    .finish_time_o      (finish_time_o),
    .turnaround_o       (turnaround_o),
    .waiting_o          (waiting_o),
    .total_turnaround_o (total_turnaround_o),
    .total_waiting_o    (total_waiting_o),
    .all_done_o         (all_done_o)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // scheduler predictor: loads fill the next slot, a tick runs the best ready process
  task automatic predict_word(input sched_word_t w, output bit has_rep,
                              output tick_report_t rep);
    int          best;
    int          i;
    logic [63:0] ta;
    logic [63:0] wt;
    logic [63:0] acc;
    rep     = '0;
    has_rep = 1'b0;
    if (w.op == OP_LOAD) begin
      if (n_loaded < SLOTS) begin
        slot_id[n_loaded]      = w.pid;
        slot_arrival[n_loaded] = w.arrival;
        slot_burst[n_loaded]   = w.burst;
        slot_left[n_loaded]    = w.burst;
        slot_prio[n_loaded]    = w.prio;
        slot_done[n_loaded]    = 1'b0;
        n_loaded++;
      end
      return;
    end
    // lowest priority number, then earliest arrival, then lowest slot
    best = -1;
    for (i = 0; i < n_loaded; i++) begin
      if (slot_done[i] || slot_arrival[i] > cur_time) continue;
      if (best < 0 || slot_prio[i] < slot_prio[best] ||
          (slot_prio[i] == slot_prio[best] && slot_arrival[i] < slot_arrival[best]))
        best = i;
    end
    if (cur_time != TIME_SAT) cur_time++;
    has_rep = 1'b1;
    if (best >= 0) begin
      rep.ran_valid = 1'b1;
      rep.ran_id    = slot_id[best];
      if (slot_left[best] <= 1) begin
        slot_left[best] = '0;
        slot_done[best] = 1'b1;
        n_done++;
        ta = 64'(cur_time) - 64'(slot_arrival[best]);
        wt = (ta >= 64'(slot_burst[best])) ? ta - 64'(slot_burst[best]) : 64'd0;
        acc    = 64'(sum_ta) + ta;
        sum_ta = (acc > 64'(SUM_SAT)) ? SUM_SAT : acc[SUM_W-1:0];
        acc    = 64'(sum_wt) + wt;
        sum_wt = (acc > 64'(SUM_SAT)) ? SUM_SAT : acc[SUM_W-1:0];
        rep.finished    = 1'b1;
        rep.finish_time = cur_time;
        rep.turnaround  = ta[CLK_W-1:0];
        rep.waiting     = wt[CLK_W-1:0];
      end else begin
        slot_left[best] = slot_left[best] - 1'b1;
      end
    end
    rep.now              = cur_time;
    rep.total_turnaround = sum_ta;
    rep.total_waiting    = sum_wt;
    rep.all_done         = (n_done == n_loaded);
  endtask

  // present one word, hold it until accepted, then record what it should produce
  task automatic issue_word(input sched_word_t w, input bit quiet, input bit has_fixed,
                            input tick_report_t fixed);
    int           gap;
    bit           has_rep;
    tick_report_t rep;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    operation    <= w.op;
    process_id   <= w.pid;
    arrival      <= w.arrival;
    burst        <= w.burst;
    priority_req <= w.prio;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(w, has_rep, rep);
    if (has_rep) expected_reports.push_back(has_fixed ? fixed : rep);
  endtask

  function automatic directed_row_t load_row(logic [ID_W-1:0] pid, logic [TIME_W-1:0] arr,
                                             logic [TIME_W-1:0] bur, logic [PRIO_W-1:0] pri);
    directed_row_t row;
    row = '0;
    row.word.op      = OP_LOAD;
    row.word.pid     = pid;
    row.word.arrival = arr;
    row.word.burst   = bur;
    row.word.prio    = pri;
    return row;
  endfunction

  function automatic directed_row_t tick_row();
    directed_row_t row;
    row = '0;
    row.word.op = OP_TICK;
    return row;
  endfunction

  // load with random content; shaped ones arrive soon and finish quickly
  function automatic sched_word_t rand_load(bit shaped);
    sched_word_t w;
    w.op   = OP_LOAD;
    w.pid  = ID_W'($urandom_range(0, 255));
    w.prio = PRIO_W'($urandom_range(0, 255));
    if (shaped) begin
      w.arrival = cur_time[TIME_W-1:0] + TIME_W'($urandom_range(0, 40));
      w.burst   = TIME_W'($urandom_range(1, 24));
      if ($urandom_range(0, 1) == 1) w.prio = PRIO_W'($urandom_range(0, 3));
    end else begin
      w.arrival = TIME_W'($urandom_range(0, 65535));
      w.burst   = TIME_W'($urandom_range(1, 65535));
    end
    return w;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // result side stall: bursts of stall with quiet stretches
  initial begin : out_stall_gen
    int n;
    forever begin
      n = (((cycle_cnt / 500) % 4) == 3) ? 0 : pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // compare each accepted report word with the oldest expectation
  always @(posedge clk_i) begin
    tick_report_t e;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("tick report with no expectation pending");
        fail_count++;
      end else begin
        e = expected_reports.pop_front();
        check_field("ran_valid", 64'(e.ran_valid), 64'(ran_valid_o));
        check_field("ran_id", 64'(e.ran_id), 64'(ran_id_o));
        check_field("now", 64'(e.now), 64'(now_o));
        check_field("finished", 64'(e.finished), 64'(finished_o));
        check_field("finish_time", 64'(e.finish_time), 64'(finish_time_o));
        check_field("turnaround", 64'(e.turnaround), 64'(turnaround_o));
        check_field("waiting", 64'(e.waiting), 64'(waiting_o));
        check_field("total_turnaround", 64'(e.total_turnaround), 64'(total_turnaround_o));
        check_field("total_waiting", 64'(e.total_waiting), 64'(total_waiting_o));
        check_field("all_done", 64'(e.all_done), 64'(all_done_o));
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    directed_row_t row;
    sched_word_t   w;
    int            n_items;
    int            idx;
    bit            quiet;

    // directed table
    row = tick_row();
    row.has_fixed      = 1'b1;
    row.fixed          = '0;
    row.fixed.now      = 1;
    row.fixed.all_done = 1'b1;
    directed_tbl.push_back(row);                                // idle tick, empty table
    directed_tbl.push_back(load_row(8'hFF, 16'd0, 16'd2, 8'hFF));
    directed_tbl.push_back(load_row(8'h00, 16'd0, 16'd0, 8'h00));   // zero burst
    directed_tbl.push_back(tick_row());                         // zero burst completes at once
    directed_tbl.push_back(load_row(8'h55, 16'hFFFF, 16'hFFFF, 8'h00)); // never arrives
    directed_tbl.push_back(load_row(8'hAA, 16'd3, 16'd1, 8'hFF));
    directed_tbl.push_back(tick_row());
    directed_tbl.push_back(tick_row());                         // equal priority, earlier arrival
    directed_tbl.push_back(tick_row());
    directed_tbl.push_back(load_row(8'h01, 16'd5, 16'd2, 8'd16));
    directed_tbl.push_back(load_row(8'h02, 16'd5, 16'd1, 8'd16));   // full tie, lower slot
    directed_tbl.push_back(tick_row());
    directed_tbl.push_back(load_row(8'h03, 16'd0, 16'd1, 8'd15));   // late load preempts
    directed_tbl.push_back(tick_row());
    directed_tbl.push_back(tick_row());
    directed_tbl.push_back(tick_row());
    directed_tbl.push_back(tick_row());                         // idle, sums unchanged
    directed_tbl.push_back(tick_row());

    // reset
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[k])
      issue_word(directed_tbl[k].word, 1'b0, directed_tbl[k].has_fixed,
                 directed_tbl[k].fixed);

    // random part: mostly ticks, loads while the table has room, noise loads after
    n_items = 0;
    idx     = 0;
    while (n_items < RAND_ITEMS) begin
      quiet = ((idx / 64) % 5) == 4;
      if ($urandom_range(0, 99) < 8) begin
        w = rand_load($urandom_range(0, 99) < 70);
      end else begin
        w = rand_load(1'b0);
        w.op = OP_TICK;
      end
      n_items++;
      issue_word(w, quiet, 1'b0, '0);
      idx++;
    end
    in_valid <= 1'b0;

    // drain
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && expected_reports.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
src/pps_pkg.sv
src/pps_ram.sv
src/pps_pick.sv
src/preemptive_priority_scheduler_unit.sv
src/pps_checker.sv
verif/tb_preemptive_priority_scheduler_unit.sv
